[rtl/core/ppmfd_pkg.sv]
// Shared types and constants of the PPM frame decoder.
package ppmfd_pkg;

   localparam int WIDTH_W     = 16;   // timer counts and pulse widths
   localparam int SLOT_OUT_W  = 4;    // slot field of a result beat
   localparam int LEVEL_W     = 11;   // signed control level
   localparam int LEVEL_MAG_W = 10;   // magnitude of a control level
   localparam int LEVEL_SCALE = 1000; // full deflection in thousandths
   localparam int CHAN_SEL_W  = 3;    // frame channel and read channel selects
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic CMD_CAPTURE = 1'b0;
   localparam logic CMD_READ    = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_PERIOD   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WIDTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VALID      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALID      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_WIDTH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_THRESHOLD = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_CHANNEL  = 3'd6;

   localparam logic [WIDTH_W-1:0]        RST_TIMER_PERIOD   = 16'd40000;
   localparam logic [WIDTH_W-1:0]        RST_SYNC_WIDTH     = 16'd5000;
   localparam logic [WIDTH_W-1:0]        RST_MIN_VALID      = 16'd1990;
   localparam logic [WIDTH_W-1:0]        RST_MAX_VALID      = 16'd4010;
   localparam logic [WIDTH_W-1:0]        RST_CENTER_WIDTH   = 16'd3000;
   localparam logic signed [LEVEL_W-1:0] RST_MODE_THRESHOLD = 11'sd700;
   localparam logic [CHAN_SEL_W-1:0]     RST_FRAME_CHANNEL  = 3'd7;

   localparam logic MODE_MANUAL    = 1'b0;
   localparam logic MODE_AUTOPILOT = 1'b1;

   // Result fields that travel down the pipeline with each beat.
   typedef struct packed {
      logic [WIDTH_W-1:0]    pulse_width;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  is_sync;
      logic                  stored;
      logic                  frame_done;
      logic                  copied;
      logic [WIDTH_W-1:0]    read_width;
   } pkt_type;

endpackage

[rtl/core/ppmfd_req_if.sv]
// Request channel of the PPM frame decoder: capture events and snapshot reads.
interface ppmfd_req_if;
   import ppmfd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [WIDTH_W-1:0]    capture_time;
   logic                  copy_hold;
   logic [CHAN_SEL_W-1:0] read_channel;

   modport source (output valid, output cmd, output capture_time, output copy_hold,
                   output read_channel, input ready);
   modport sink   (input valid, input cmd, input capture_time, input copy_hold,
                   input read_channel, output ready);
endinterface

[rtl/core/ppmfd_rsp_if.sv]
// Response channel of the PPM frame decoder: one beat per request.
interface ppmfd_rsp_if;
   import ppmfd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [WIDTH_W-1:0]        pulse_width;
   logic [SLOT_OUT_W-1:0]     slot;
   logic                      is_sync;
   logic                      stored;
   logic                      frame_done;
   logic                      copied;
   logic                      flight_mode;
   logic signed [LEVEL_W-1:0] aux_level;
   logic [WIDTH_W-1:0]        read_width;

   modport source (output valid, output pulse_width, output slot, output is_sync,
                   output stored, output frame_done, output copied, output flight_mode,
                   output aux_level, output read_width, input ready);
   modport sink   (input valid, input pulse_width, input slot, input is_sync,
                   input stored, input frame_done, input copied, input flight_mode,
                   input aux_level, input read_width, output ready);
endinterface

[rtl/core/ppm_frame_decoder_unit.sv]
// Top level of the PPM frame decoder: pulse measurement, slot tracking and mode decision.
//
// The decoder takes one request beat per clock while the response side is not stalled, and
// returns one response beat per request, in order; each beat passes through the stage
// registers A, B, C, D and O before it is presented. The
// first stage measures the pulse width, updates the slot counter, the latest widths and
// the snapshot, and returns snapshot reads; the next three stages scale the mode channel
// to thousandths (a constant multiply, a reciprocal multiply, then a single correction
// step) and the last stage updates the level and flight mode registers. Every stage holds
// one beat with its own valid bit, so the request side keeps accepting beats while a
// response waits, until the pipeline has filled. Configuration writes are meant for idle
// periods only.
module ppm_frame_decoder_unit #(
   parameter int CHANNELS     = 8,
   parameter int MODE_CHANNEL = 6,
   parameter int HALF_SPAN    = 1000
) (
   input  logic                               clock,
   input  logic                               reset,
   ppmfd_req_if.sink                          req_bus,
   ppmfd_rsp_if.source                        rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [ppmfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ppmfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ppmfd_pkg::*;

   localparam int SLOT_W   = $clog2(CHANNELS + 1);
   localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam bit MODE_OK  = (MODE_CHANNEL < CHANNELS);
   localparam int MODE_IDX = MODE_OK ? MODE_CHANNEL : 0;
   localparam int MAG_W    = $clog2(HALF_SPAN + 1);
   localparam int N_W      = $clog2(HALF_SPAN * LEVEL_SCALE + 1);
   localparam int RECIP_SHIFT = N_W;
   localparam int RECIP    = (2 ** RECIP_SHIFT) / HALF_SPAN;
   localparam int R_W      = $clog2(RECIP + 1);
   localparam int P_W      = N_W + R_W;
   localparam int CMP_W    = $clog2(1024 * HALF_SPAN + 1) + 1;

   localparam logic [SLOT_W-1:0]       SLOT_MAX = SLOT_W'(CHANNELS);
   localparam logic signed [16:0]      HS_D     = 17'(HALF_SPAN);
   localparam logic [MAG_W-1:0]        HS_MAG   = MAG_W'(HALF_SPAN);
   localparam logic [N_W-1:0]          HS_N     = N_W'(HALF_SPAN);
   localparam logic signed [CMP_W-1:0] HS_C     = CMP_W'(HALF_SPAN);

   // Configuration registers.
   logic [WIDTH_W-1:0]        period_ff, sync_ff, min_ff, max_ff, center_ff;
   logic signed [LEVEL_W-1:0] thr_ff;
   logic [CHAN_SEL_W-1:0]     frame_ff;
   logic signed [CMP_W-1:0]   thr_scaled_ff;

   // Decoder state.
   logic [WIDTH_W-1:0] last_ff, last_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [WIDTH_W-1:0] latest_ff [CHANNELS];
   logic [WIDTH_W-1:0] latest_in [CHANNELS];
   logic [WIDTH_W-1:0] snap_ff [CHANNELS];
   logic               mode_ff, mode_in;
   logic signed [LEVEL_W-1:0] aux_ff, aux_in;

   // Pipeline stages.
   logic                  a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, o_valid_ff;
   logic                  en_a, en_b, en_c, en_d, en_o, fire_a;
   logic                  a_cmd_ff, a_hold_ff;
   logic [WIDTH_W-1:0]    a_cap_ff;
   logic [CHAN_SEL_W-1:0] a_rch_ff;
   pkt_type               a_pkt, b_pkt_ff, c_pkt_ff, d_pkt_ff, o_pkt_ff;
   logic [MAG_W-1:0]      a_dmag, b_dmag_ff;
   logic                  a_dneg, b_dneg_ff, c_dneg_ff, d_dneg_ff;
   logic [N_W-1:0]        c_n_ff, d_n_ff, n_in;
   logic [P_W-1:0]        d_prod_ff, prod_in;
   logic                  d_manual_ff, manual_in;
   logic                  o_mode_ff;
   logic signed [LEVEL_W-1:0] o_aux_ff;

   // Stage A combinational signals.
   logic [16:0]         sum_w;
   logic [WIDTH_W-1:0]  width;
   logic                is_capture, is_sync, in_window, slot_lt, store, done, copy;
   logic [IDX_W-1:0]    slot_idx, rd_idx;
   logic                rd_ok;
   logic [WIDTH_W-1:0]  mode_w;
   logic signed [16:0]  d_raw, d_abs;

   // Stage C and D combinational signals.
   logic signed [CMP_W-1:0] n_signed;
   logic [LEVEL_MAG_W-1:0]  q0, q;
   logic [N_W-1:0]          q0_mul, rem;

   // Each stage loads when it is empty or its beat moves on.
   assign en_o = !o_valid_ff || rsp_bus.ready;
   assign en_d = !d_valid_ff || en_o;
   assign en_c = !c_valid_ff || en_d;
   assign en_b = !b_valid_ff || en_c;
   assign en_a = !a_valid_ff || en_b;
   assign fire_a = a_valid_ff && en_b;
   // No request beat is taken while reset is held.
   assign req_bus.ready = en_a && !reset;

   // Configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= RST_TIMER_PERIOD;
         sync_ff   <= RST_SYNC_WIDTH;
         min_ff    <= RST_MIN_VALID;
         max_ff    <= RST_MAX_VALID;
         center_ff <= RST_CENTER_WIDTH;
         thr_ff    <= RST_MODE_THRESHOLD;
         frame_ff  <= RST_FRAME_CHANNEL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TIMER_PERIOD:   period_ff <= csr_wdata;
            CSR_SYNC_WIDTH:     sync_ff   <= csr_wdata;
            CSR_MIN_VALID:      min_ff    <= csr_wdata;
            CSR_MAX_VALID:      max_ff    <= csr_wdata;
            CSR_CENTER_WIDTH:   center_ff <= csr_wdata;
            CSR_MODE_THRESHOLD: thr_ff    <= $signed(csr_wdata[LEVEL_W-1:0]);
            CSR_FRAME_CHANNEL:  frame_ff  <= csr_wdata[CHAN_SEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The threshold in the same units as the scaled deviation.
   always_ff @(posedge clock) begin
      thr_scaled_ff <= CMP_W'(thr_ff) * HS_C;
   end

   // Stage A: width measurement, slot tracking and storage.
   always_comb begin
      is_capture = (a_cmd_ff == CMD_CAPTURE);
      sum_w = {1'b0, a_cap_ff} + {1'b0, period_ff};
      if (a_cap_ff < last_ff) begin
         width = (sum_w >= {1'b0, last_ff}) ? 16'(sum_w - {1'b0, last_ff}) : '0;
      end else begin
         width = a_cap_ff - last_ff;
      end

      is_sync   = is_capture && (width > sync_ff);
      slot_lt   = (slot_ff < SLOT_MAX);
      slot_idx  = IDX_W'(slot_ff);
      in_window = (width < max_ff) && (width > min_ff);
      store     = is_capture && !is_sync && in_window && slot_lt;
      done      = store && (5'(slot_ff) == 5'(frame_ff));
      copy      = done && !a_hold_ff;

      for (int i = 0; i < CHANNELS; i++) begin
         latest_in[i] = (store && slot_idx == IDX_W'(i)) ? width : latest_ff[i];
      end

      if (!is_capture) begin
         last_in = last_ff;
         slot_in = slot_ff;
      end else if (is_sync) begin
         last_in = a_cap_ff;
         slot_in = '0;
      end else begin
         last_in = a_cap_ff;
         slot_in = slot_lt ? slot_ff + 1'b1 : slot_ff;
      end

      rd_ok  = (5'(a_rch_ff) < 5'(CHANNELS));
      rd_idx = IDX_W'(a_rch_ff);

      a_pkt.pulse_width = is_capture ? width : '0;
      a_pkt.slot        = (is_capture && !is_sync) ? SLOT_OUT_W'(slot_ff) : '0;
      a_pkt.is_sync     = is_sync;
      a_pkt.stored      = store;
      a_pkt.frame_done  = done;
      a_pkt.copied      = copy;
      a_pkt.read_width  = (!is_capture && rd_ok) ? snap_ff[rd_idx] : '0;

      // Mode channel deviation from center, clamped to the half span.
      mode_w = MODE_OK ? latest_in[MODE_IDX] : '0;
      d_raw  = $signed({1'b0, mode_w}) - $signed({1'b0, center_ff});
      d_abs  = -d_raw;
      if (d_raw > HS_D) begin
         a_dmag = HS_MAG;
         a_dneg = 1'b0;
      end else if (d_raw < -HS_D) begin
         a_dmag = HS_MAG;
         a_dneg = 1'b1;
      end else if (d_raw < 0) begin
         a_dmag = MAG_W'(d_abs);
         a_dneg = 1'b1;
      end else begin
         a_dmag = MAG_W'(d_raw);
         a_dneg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         slot_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            latest_ff[i] <= '0;
            snap_ff[i]   <= '0;
         end
      end else if (fire_a) begin
         last_ff <= last_in;
         slot_ff <= slot_in;
         for (int i = 0; i < CHANNELS; i++) begin
            latest_ff[i] <= latest_in[i];
            if (copy) begin
               snap_ff[i] <= latest_in[i];
            end
         end
      end
   end

   // Stage B, C and D arithmetic: level = trunc(|d| * 1000 / HALF_SPAN).
   always_comb begin
      n_in      = N_W'(b_dmag_ff) * N_W'(LEVEL_SCALE);
      prod_in   = P_W'(c_n_ff) * P_W'(RECIP);
      n_signed  = c_dneg_ff ? -CMP_W'(c_n_ff) : CMP_W'(c_n_ff);
      manual_in = (n_signed <= thr_scaled_ff);

      // The reciprocal estimate is low by at most one.
      q0     = LEVEL_MAG_W'(d_prod_ff >> RECIP_SHIFT);
      q0_mul = N_W'(q0) * HS_N;
      rem    = d_n_ff - q0_mul;
      q      = (rem >= HS_N) ? q0 + 1'b1 : q0;

      if (d_pkt_ff.frame_done) begin
         aux_in  = d_dneg_ff ? -LEVEL_W'(q) : LEVEL_W'(q);
         mode_in = d_manual_ff ? MODE_MANUAL : MODE_AUTOPILOT;
      end else begin
         aux_in  = aux_ff;
         mode_in = mode_ff;
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         mode_ff    <= MODE_MANUAL;
         aux_ff     <= '0;
      end else begin
         if (en_a) a_valid_ff <= req_bus.valid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
         if (en_d) d_valid_ff <= c_valid_ff;
         if (en_o) begin
            o_valid_ff <= d_valid_ff;
            if (d_valid_ff) begin
               mode_ff <= mode_in;
               aux_ff  <= aux_in;
            end
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (en_a) begin
         a_cmd_ff  <= req_bus.cmd;
         a_cap_ff  <= req_bus.capture_time;
         a_hold_ff <= req_bus.copy_hold;
         a_rch_ff  <= req_bus.read_channel;
      end
      if (en_b) begin
         b_pkt_ff  <= a_pkt;
         b_dmag_ff <= a_dmag;
         b_dneg_ff <= a_dneg;
      end
      if (en_c) begin
         c_pkt_ff  <= b_pkt_ff;
         c_n_ff    <= n_in;
         c_dneg_ff <= b_dneg_ff;
      end
      if (en_d) begin
         d_pkt_ff    <= c_pkt_ff;
         d_n_ff      <= c_n_ff;
         d_prod_ff   <= prod_in;
         d_dneg_ff   <= c_dneg_ff;
         d_manual_ff <= manual_in;
      end
      if (en_o) begin
         o_pkt_ff  <= d_pkt_ff;
         o_mode_ff <= mode_in;
         o_aux_ff  <= aux_in;
      end
   end

   assign rsp_bus.valid       = o_valid_ff;
   assign rsp_bus.pulse_width = o_pkt_ff.pulse_width;
   assign rsp_bus.slot        = o_pkt_ff.slot;
   assign rsp_bus.is_sync     = o_pkt_ff.is_sync;
   assign rsp_bus.stored      = o_pkt_ff.stored;
   assign rsp_bus.frame_done  = o_pkt_ff.frame_done;
   assign rsp_bus.copied      = o_pkt_ff.copied;
   assign rsp_bus.flight_mode = o_mode_ff;
   assign rsp_bus.aux_level   = o_aux_ff;
   assign rsp_bus.read_width  = o_pkt_ff.read_width;

`ifndef NO_ASSERTIONS
   // A completed frame always comes from a stored pulse, and a copy only from a frame.
   a_done_needs_store: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.frame_done |-> rsp_bus.stored)
      else $error("frame completed without a stored pulse");

   a_copy_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.copied |-> rsp_bus.frame_done)
      else $error("snapshot copied outside a frame completion");

   a_sync_restarts: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_sync |-> (rsp_bus.slot == '0) && !rsp_bus.stored)
      else $error("sync beat carries a slot or a stored pulse");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_MAX)
      else $error("slot counter beyond the channel count");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (aux_ff <= 11'sd1000) && (aux_ff >= -11'sd1000))
      else $error("control level out of range");

   a_sync_clears_slot: assert property (@(posedge clock) disable iff (reset)
      fire_a && is_sync |=> slot_ff == '0)
      else $error("sync gap did not restart the slot counter");
`endif

endmodule
